// ===== src/cbct_pkg.sv =====
// ----------------------------------------------------------------------------
// cbct_pkg: shared types and constants of the circle/box contact test
// Holds the transfer structs of both channels and the step counts of the
// pipelined arithmetic units.
// ----------------------------------------------------------------------------
package cbct_pkg;

   localparam logic [1:0] KIND_CIRCLE = 2'd0;
   localparam logic [1:0] KIND_RECT   = 2'd1;
   localparam logic [1:0] KIND_POLY   = 2'd2;

   localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
   localparam logic [30:0]        DEPTH_MAX = 31'h7FFF_FFFF;

   // One root bit per stage for a 64-bit radicand.
   localparam int SQRT_STEPS = 32;
   // One quotient bit per stage; the normal magnitude never exceeds 2^14.
   localparam int DIV_STEPS  = 15;

   typedef struct packed {
      logic [1:0]          kind_a;
      logic [1:0]          kind_b;
      logic signed [31:0]  pos_a_x;
      logic signed [31:0]  pos_a_y;
      logic signed [31:0]  pos_b_x;
      logic signed [31:0]  pos_b_y;
      logic [30:0]         size_a_w;
      logic [30:0]         size_a_h;
      logic [30:0]         size_b_w;
      logic [30:0]         size_b_h;
   } req_type;

   typedef struct packed {
      logic                hit;
      logic signed [15:0]  normal_x;
      logic signed [15:0]  normal_y;
      logic signed [31:0]  start_x;
      logic signed [31:0]  start_y;
      logic signed [31:0]  end_x;
      logic signed [31:0]  end_y;
      logic [30:0]         depth;
   } rsp_type;

endpackage

// ===== src/cbct_isqrt.sv =====
// ----------------------------------------------------------------------------
// cbct_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit resolved per stage.
// ----------------------------------------------------------------------------
module cbct_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        valid_in,
   input  logic [63:0] radicand,
   output logic        valid_out,
   output logic [31:0] root
);
   import cbct_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [63:0] rem_ff  [SQRT_STEPS];
   logic [63:0] rem_in  [SQRT_STEPS];
   logic [63:0] rem_cur [SQRT_STEPS];
   logic [63:0] res_ff  [SQRT_STEPS];
   logic [63:0] res_in  [SQRT_STEPS];
   logic [63:0] res_cur [SQRT_STEPS];

   assign rem_cur[0] = radicand;
   assign res_cur[0] = '0;

   for (genvar g = 1; g < SQRT_STEPS; g++) begin : g_link
      assign rem_cur[g] = rem_ff[g-1];
      assign res_cur[g] = res_ff[g-1];
   end

   always_comb begin
      logic [63:0] trial_bit;
      logic [63:0] trial;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         trial_bit = 64'd1 << (2 * (SQRT_STEPS - 1 - i));
         trial     = res_cur[i] + trial_bit;
         if (rem_cur[i] >= trial) begin
            rem_in[i] = rem_cur[i] - trial;
            res_in[i] = (res_cur[i] >> 1) + trial_bit;
         end else begin
            rem_in[i] = rem_cur[i];
            res_in[i] = res_cur[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQRT_STEPS-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SQRT_STEPS; i++) begin
         rem_ff[i] <= rem_in[i];
         res_ff[i] <= res_in[i];
      end
   end

   assign valid_out = valid_ff[SQRT_STEPS-1];
   assign root      = res_ff[SQRT_STEPS-1][31:0];

endmodule

// ===== src/cbct_div.sv =====
// ----------------------------------------------------------------------------
// cbct_div: pipelined restoring divider
// Computes floor(num * 2^14 / den) for quotients below 2^15, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module cbct_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  logic [30:0]                    num,
   input  logic [31:0]                    den,
   output logic                           valid_out,
   output logic [cbct_pkg::DIV_STEPS-1:0] quo
);
   import cbct_pkg::*;

   localparam int REM_W = 31 + DIV_STEPS - 1;

   logic [DIV_STEPS-1:0] valid_ff;
   logic [REM_W-1:0]     rem_ff  [DIV_STEPS];
   logic [REM_W-1:0]     rem_in  [DIV_STEPS];
   logic [REM_W-1:0]     rem_cur [DIV_STEPS];
   logic [31:0]          den_ff  [DIV_STEPS];
   logic [31:0]          den_cur [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff  [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_in  [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_cur [DIV_STEPS];

   assign rem_cur[0] = {num, {(DIV_STEPS-1){1'b0}}};
   assign den_cur[0] = den;
   assign quo_cur[0] = '0;

   for (genvar g = 1; g < DIV_STEPS; g++) begin : g_link
      assign rem_cur[g] = rem_ff[g-1];
      assign den_cur[g] = den_ff[g-1];
      assign quo_cur[g] = quo_ff[g-1];
   end

   always_comb begin
      logic [REM_W:0] trial;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = (REM_W+1)'(den_cur[i]) << (DIV_STEPS - 1 - i);
         if ({1'b0, rem_cur[i]} >= trial) begin
            rem_in[i] = rem_cur[i] - trial[REM_W-1:0];
            quo_in[i] = quo_cur[i] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - i));
         end else begin
            rem_in[i] = rem_cur[i];
            quo_in[i] = quo_cur[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DIV_STEPS-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_cur[i];
         quo_ff[i] <= quo_in[i];
      end
   end

   assign valid_out = valid_ff[DIV_STEPS-1];
   assign quo       = quo_ff[DIV_STEPS-1];

endmodule

// ===== src/circle_box_contact_test_core.sv =====
// ----------------------------------------------------------------------------
// circle_box_contact_test_core: narrow-phase contact test for shape pairs
// Circle/circle and box/box contact with normal, contact points and depth.
//
//   channel  ports                     direction  transfer
//   req      start, busy, req_data     in         start high, busy low
//   rsp      rsp_valid, rsp_data       out        rsp_valid high, one cycle
//
// One pair is taken every cycle; busy is always low.
// The pipeline is five front stages, a 32-stage square root for the
// centre distance, a 15-stage divider for the normal, five contact stages,
// a 32-stage square root for the depth and the output register.
// Synchronous reset clears only the valid bits; pairs in flight are lost, none are held.
// The receiver cannot stall, so the pipeline never stops.
// ----------------------------------------------------------------------------
module circle_box_contact_test_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cbct_pkg::req_type req_data,
   output logic              rsp_valid,
   output cbct_pkg::rsp_type rsp_data
);
   import cbct_pkg::*;

   typedef struct packed {
      logic               circ;
      logic               hit;
      logic               zero;
      logic               neg_x;
      logic               neg_y;
      logic [30:0]        mag_x;
      logic [30:0]        mag_y;
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic [30:0]        rad_a;
      logic [30:0]        rad_b;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } side_type;

   typedef struct packed {
      rsp_type res;
      logic    big;
   } dside_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -34'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [33:0] edge_lo(input logic signed [31:0] p,
                                                  input logic [30:0] s);
      return $signed({p[31], p, 1'b0}) - $signed({3'b0, s});
   endfunction

   function automatic logic signed [33:0] edge_hi(input logic signed [31:0] p,
                                                  input logic [30:0] s);
      return $signed({p[31], p, 1'b0}) + $signed({3'b0, s});
   endfunction

   // Stage 1: input register.
   logic    v1_ff;
   req_type req1_ff;

   // Stage 2: differences, radius sum and doubled box edges.
   logic               v2_ff, circ2_ff, box2_ff, neg_x2_ff, neg_y2_ff;
   logic [31:0]        ux2_ff, uy2_ff, rsum2_ff;
   logic signed [33:0] la2_ff, ra2_ff, ta2_ff, ba2_ff;
   logic signed [33:0] lb2_ff, rb2_ff, tb2_ff, bb2_ff;
   req_type            req2_ff;
   logic               circ2_in, box2_in;
   logic signed [32:0] dx2, dy2;
   logic [32:0]        ux2_in, uy2_in;

   // Stage 3: squares and box overlap.
   logic               v3_ff, circ3_ff, box3_ff, neg_x3_ff, neg_y3_ff;
   logic [31:0]        ux3_ff, uy3_ff;
   logic [63:0]        sq_x3_ff, sq_y3_ff, sq_r3_ff;
   logic               ovl3_ff, rlt3_ff, blt3_ff;
   logic signed [33:0] lmax3_ff, rmin3_ff, tmax3_ff, bmin3_ff;
   req_type            req3_ff;

   // Stage 4: hit decision and box contact.
   logic               v4_ff;
   side_type           side4_ff, side4_in;
   logic [64:0]        dist4;
   logic               chit4, xsmall4, halve4;
   logic signed [34:0] ovx4, ovy4;

   // Stage 5: squared length for the normal.
   logic        v5_ff;
   side_type    side5_ff;
   logic [62:0] q5_ff;

   logic        sq1_valid;
   logic [31:0] len1;
   side_type    side1_ff [SQRT_STEPS];

   logic                 dvx_valid, dvy_valid;
   logic [DIV_STEPS-1:0] quo_x, quo_y;
   side_type             side2_ff [DIV_STEPS];

   // Stage 6: signed normal.
   logic     v6_ff;
   side_type side6_ff, side6_in;

   // Stage 7: normal times radius.
   logic        v7_ff;
   side_type    side7_ff;
   logic [30:0] pax7_ff, pay7_ff, pbx7_ff, pby7_ff;
   logic [14:0] nmx7, nmy7;
   logic [45:0] mul_ax7, mul_ay7, mul_bx7, mul_by7;

   // Stage 8: contact points.
   logic               v8_ff;
   rsp_type            res8_ff, res8_in;
   logic signed [33:0] off_ax8, off_ay8, off_bx8, off_by8;

   // Stage 9: contact extent magnitudes.
   logic               v9_ff, big9_ff;
   rsp_type            res9_ff;
   logic [30:0]        mdx9_ff, mdy9_ff;
   logic signed [32:0] ddx9, ddy9;
   logic [32:0]        mgx9, mgy9;

   // Stage 10: squared contact length.
   logic        v10_ff;
   dside_type   ds10_ff;
   logic [62:0] dsq10_ff;

   logic        sq2_valid;
   logic [31:0] droot;
   dside_type   ds_dly_ff [SQRT_STEPS];

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type res_out;

   assign busy = 1'b0;

   // ------------------------------------------------------------------ valid
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= start && !busy;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= dvx_valid;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= v9_ff;
         rsp_valid_ff <= sq2_valid;
      end
   end

   // ---------------------------------------------------------------- stage 2
   always_comb begin
      circ2_in = (req1_ff.kind_a == KIND_CIRCLE) && (req1_ff.kind_b == KIND_CIRCLE);
      box2_in  = ((req1_ff.kind_a == KIND_RECT) || (req1_ff.kind_a == KIND_POLY)) &&
                 ((req1_ff.kind_b == KIND_RECT) || (req1_ff.kind_b == KIND_POLY));
      dx2 = $signed({req1_ff.pos_b_x[31], req1_ff.pos_b_x}) -
            $signed({req1_ff.pos_a_x[31], req1_ff.pos_a_x});
      dy2 = $signed({req1_ff.pos_b_y[31], req1_ff.pos_b_y}) -
            $signed({req1_ff.pos_a_y[31], req1_ff.pos_a_y});
      ux2_in = dx2[32] ? 33'(-dx2) : 33'(dx2);
      uy2_in = dy2[32] ? 33'(-dy2) : 33'(dy2);
   end

   // ---------------------------------------------------------------- stage 4
   always_comb begin
      dist4   = {1'b0, sq_x3_ff} + {1'b0, sq_y3_ff};
      chit4   = !dist4[64] && (dist4[63:0] <= sq_r3_ff);
      halve4  = ux3_ff[31] || uy3_ff[31];
      ovx4    = $signed({rmin3_ff[33], rmin3_ff}) - $signed({lmax3_ff[33], lmax3_ff});
      ovy4    = $signed({bmin3_ff[33], bmin3_ff}) - $signed({tmax3_ff[33], tmax3_ff});
      xsmall4 = ovx4 < ovy4;

      side4_in.circ    = circ3_ff;
      side4_in.hit     = (circ3_ff && chit4) || (box3_ff && ovl3_ff);
      side4_in.zero    = (ux3_ff == '0) && (uy3_ff == '0);
      side4_in.neg_x   = neg_x3_ff;
      side4_in.neg_y   = neg_y3_ff;
      // Very long distances are halved on both axes before the root.
      side4_in.mag_x   = halve4 ? ux3_ff[31:1] : ux3_ff[30:0];
      side4_in.mag_y   = halve4 ? uy3_ff[31:1] : uy3_ff[30:0];
      side4_in.pos_a_x = req3_ff.pos_a_x;
      side4_in.pos_a_y = req3_ff.pos_a_y;
      side4_in.pos_b_x = req3_ff.pos_b_x;
      side4_in.pos_b_y = req3_ff.pos_b_y;
      side4_in.rad_a   = req3_ff.size_a_w;
      side4_in.rad_b   = req3_ff.size_b_w;
      if (xsmall4) begin
         side4_in.norm_x = rlt3_ff ? UNIT_Q14 : -UNIT_Q14;
         side4_in.norm_y = '0;
      end else begin
         side4_in.norm_x = '0;
         side4_in.norm_y = blt3_ff ? UNIT_Q14 : -UNIT_Q14;
      end
      // Arithmetic shift of a doubled edge rounds toward minus infinity.
      side4_in.start_x = sat32(lmax3_ff >>> 1);
      side4_in.start_y = sat32(tmax3_ff >>> 1);
      side4_in.end_x   = sat32(rmin3_ff >>> 1);
      side4_in.end_y   = sat32(bmin3_ff >>> 1);
   end

   // --------------------------------------------------------- front payload
   always_ff @(posedge clock) begin
      req1_ff <= req_data;

      circ2_ff  <= circ2_in;
      box2_ff   <= box2_in;
      neg_x2_ff <= dx2[32];
      neg_y2_ff <= dy2[32];
      ux2_ff    <= ux2_in[31:0];
      uy2_ff    <= uy2_in[31:0];
      rsum2_ff  <= {1'b0, req1_ff.size_a_w} + {1'b0, req1_ff.size_b_w};
      la2_ff    <= edge_lo(req1_ff.pos_a_x, req1_ff.size_a_w);
      ra2_ff    <= edge_hi(req1_ff.pos_a_x, req1_ff.size_a_w);
      ta2_ff    <= edge_lo(req1_ff.pos_a_y, req1_ff.size_a_h);
      ba2_ff    <= edge_hi(req1_ff.pos_a_y, req1_ff.size_a_h);
      lb2_ff    <= edge_lo(req1_ff.pos_b_x, req1_ff.size_b_w);
      rb2_ff    <= edge_hi(req1_ff.pos_b_x, req1_ff.size_b_w);
      tb2_ff    <= edge_lo(req1_ff.pos_b_y, req1_ff.size_b_h);
      bb2_ff    <= edge_hi(req1_ff.pos_b_y, req1_ff.size_b_h);
      req2_ff   <= req1_ff;

      circ3_ff  <= circ2_ff;
      box3_ff   <= box2_ff;
      neg_x3_ff <= neg_x2_ff;
      neg_y3_ff <= neg_y2_ff;
      ux3_ff    <= ux2_ff;
      uy3_ff    <= uy2_ff;
      sq_x3_ff  <= 64'(ux2_ff) * 64'(ux2_ff);
      sq_y3_ff  <= 64'(uy2_ff) * 64'(uy2_ff);
      sq_r3_ff  <= 64'(rsum2_ff) * 64'(rsum2_ff);
      ovl3_ff   <= (ra2_ff >= lb2_ff) && (rb2_ff >= la2_ff) &&
                   (ba2_ff >= tb2_ff) && (bb2_ff >= ta2_ff);
      lmax3_ff  <= (la2_ff > lb2_ff) ? la2_ff : lb2_ff;
      rmin3_ff  <= (ra2_ff < rb2_ff) ? ra2_ff : rb2_ff;
      tmax3_ff  <= (ta2_ff > tb2_ff) ? ta2_ff : tb2_ff;
      bmin3_ff  <= (ba2_ff < bb2_ff) ? ba2_ff : bb2_ff;
      rlt3_ff   <= ra2_ff < rb2_ff;
      blt3_ff   <= ba2_ff < bb2_ff;
      req3_ff   <= req2_ff;

      side4_ff <= side4_in;

      side5_ff <= side4_ff;
      q5_ff    <= 63'(62'(side4_ff.mag_x) * 62'(side4_ff.mag_x)) +
                  63'(62'(side4_ff.mag_y) * 62'(side4_ff.mag_y));
   end

   // ------------------------------------------------------ normal length
   cbct_isqrt u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v5_ff),
      .radicand  ({1'b0, q5_ff}),
      .valid_out (sq1_valid),
      .root      (len1)
   );

   always_ff @(posedge clock) begin
      side1_ff[0] <= side5_ff;
      for (int i = 1; i < SQRT_STEPS; i++) begin
         side1_ff[i] <= side1_ff[i-1];
      end
   end

   cbct_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sq1_valid),
      .num       (side1_ff[SQRT_STEPS-1].mag_x),
      .den       (len1),
      .valid_out (dvx_valid),
      .quo       (quo_x)
   );

   cbct_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sq1_valid),
      .num       (side1_ff[SQRT_STEPS-1].mag_y),
      .den       (len1),
      .valid_out (dvy_valid),
      .quo       (quo_y)
   );

   always_ff @(posedge clock) begin
      side2_ff[0] <= side1_ff[SQRT_STEPS-1];
      for (int i = 1; i < DIV_STEPS; i++) begin
         side2_ff[i] <= side2_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- stage 6
   always_comb begin
      side6_in = side2_ff[DIV_STEPS-1];
      if (side6_in.circ) begin
         // Coincident centres leave the divider output meaningless.
         if (side6_in.zero) begin
            side6_in.norm_x = '0;
            side6_in.norm_y = '0;
         end else begin
            side6_in.norm_x = side6_in.neg_x ? -$signed({1'b0, quo_x}) :
                                               $signed({1'b0, quo_x});
            side6_in.norm_y = side6_in.neg_y ? -$signed({1'b0, quo_y}) :
                                               $signed({1'b0, quo_y});
         end
      end
   end

   // ---------------------------------------------------------------- stage 7
   always_comb begin
      nmx7    = side6_ff.norm_x[15] ? 15'(-side6_ff.norm_x) : side6_ff.norm_x[14:0];
      nmy7    = side6_ff.norm_y[15] ? 15'(-side6_ff.norm_y) : side6_ff.norm_y[14:0];
      mul_ax7 = 46'(nmx7) * 46'(side6_ff.rad_a);
      mul_ay7 = 46'(nmy7) * 46'(side6_ff.rad_a);
      mul_bx7 = 46'(nmx7) * 46'(side6_ff.rad_b);
      mul_by7 = 46'(nmy7) * 46'(side6_ff.rad_b);
   end

   // ---------------------------------------------------------------- stage 8
   always_comb begin
      off_ax8 = side7_ff.norm_x[15] ? -$signed({3'b0, pax7_ff}) : $signed({3'b0, pax7_ff});
      off_ay8 = side7_ff.norm_y[15] ? -$signed({3'b0, pay7_ff}) : $signed({3'b0, pay7_ff});
      off_bx8 = side7_ff.norm_x[15] ? -$signed({3'b0, pbx7_ff}) : $signed({3'b0, pbx7_ff});
      off_by8 = side7_ff.norm_y[15] ? -$signed({3'b0, pby7_ff}) : $signed({3'b0, pby7_ff});

      res8_in.hit      = side7_ff.hit;
      res8_in.normal_x = side7_ff.norm_x;
      res8_in.normal_y = side7_ff.norm_y;
      res8_in.depth    = '0;
      if (side7_ff.circ) begin
         res8_in.start_x = sat32(34'(side7_ff.pos_b_x) - off_bx8);
         res8_in.start_y = sat32(34'(side7_ff.pos_b_y) - off_by8);
         res8_in.end_x   = sat32(34'(side7_ff.pos_a_x) + off_ax8);
         res8_in.end_y   = sat32(34'(side7_ff.pos_a_y) + off_ay8);
      end else begin
         res8_in.start_x = side7_ff.start_x;
         res8_in.start_y = side7_ff.start_y;
         res8_in.end_x   = side7_ff.end_x;
         res8_in.end_y   = side7_ff.end_y;
      end
   end

   // ---------------------------------------------------------------- stage 9
   always_comb begin
      ddx9 = $signed({res8_ff.end_x[31], res8_ff.end_x}) -
             $signed({res8_ff.start_x[31], res8_ff.start_x});
      ddy9 = $signed({res8_ff.end_y[31], res8_ff.end_y}) -
             $signed({res8_ff.start_y[31], res8_ff.start_y});
      mgx9 = ddx9[32] ? 33'(-ddx9) : 33'(ddx9);
      mgy9 = ddy9[32] ? 33'(-ddy9) : 33'(ddy9);
   end

   // ---------------------------------------------------------- back payload
   always_ff @(posedge clock) begin
      side6_ff <= side6_in;

      side7_ff <= side6_ff;
      pax7_ff  <= mul_ax7[44:14];
      pay7_ff  <= mul_ay7[44:14];
      pbx7_ff  <= mul_bx7[44:14];
      pby7_ff  <= mul_by7[44:14];

      res8_ff <= res8_in;

      res9_ff <= res8_ff;
      mdx9_ff <= mgx9[30:0];
      mdy9_ff <= mgy9[30:0];
      // An extent of 2^31 or more on either axis saturates the depth.
      big9_ff <= (mgx9[32:31] != 2'b00) || (mgy9[32:31] != 2'b00);

      ds10_ff.res <= res9_ff;
      ds10_ff.big <= big9_ff;
      dsq10_ff    <= 63'(62'(mdx9_ff) * 62'(mdx9_ff)) +
                     63'(62'(mdy9_ff) * 62'(mdy9_ff));
   end

   // ------------------------------------------------------------ depth root
   cbct_isqrt u_depth_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (v10_ff),
      .radicand  ({1'b0, dsq10_ff}),
      .valid_out (sq2_valid),
      .root      (droot)
   );

   always_ff @(posedge clock) begin
      ds_dly_ff[0] <= ds10_ff;
      for (int i = 1; i < SQRT_STEPS; i++) begin
         ds_dly_ff[i] <= ds_dly_ff[i-1];
      end
   end

   always_comb begin
      res_out = ds_dly_ff[SQRT_STEPS-1].res;
      if (ds_dly_ff[SQRT_STEPS-1].big || droot[31]) begin
         res_out.depth = DEPTH_MAX;
      end else begin
         res_out.depth = droot[30:0];
      end
      rsp_data_in = res_out.hit ? res_out : '0;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------- assertions
   // A box contact always carries a normal along exactly one axis.
   assert property (@(posedge clock) disable iff (reset)
      (v6_ff && side6_ff.hit && !side6_ff.circ) |->
         ((side6_ff.norm_x == '0) != (side6_ff.norm_y == '0)))
   else $error("box contact normal is not axis aligned");

   // A circle normal never exceeds unit length on either axis.
   assert property (@(posedge clock) disable iff (reset)
      (v6_ff && side6_ff.hit && side6_ff.circ) |->
         ((side6_ff.norm_x <= UNIT_Q14) && (side6_ff.norm_x >= -UNIT_Q14) &&
          (side6_ff.norm_y <= UNIT_Q14) && (side6_ff.norm_y >= -UNIT_Q14)))
   else $error("circle normal component out of range");

   // Both normal dividers run in lockstep.
   assert property (@(posedge clock) disable iff (reset)
      dvx_valid == dvy_valid)
   else $error("normal dividers out of step");

endmodule
